/* sv/cbq_pkg.sv */
// Shared types and constants for the circular byte queue.
package cbq_pkg;

  localparam int CBQ_DEPTH = 64;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 8;
  localparam int OFFS_W = 7;

  // Total input item width and its byte-rounded tdata width.
  localparam int IN_RAW_W = FUNC_W + DATA_W + OFFS_W;
  localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_POP_RET = 3'd2,
    FUNC_PEEK    = 3'd3,
    FUNC_DROP    = 3'd4
  } func_e;

endpackage

/* sv/circular_byte_queue.sv */
// Top level of the circular byte queue: pointer control, result stages and storage.
//
// A ring buffer of DEPTH bytes driven by one operation per input item.
// Input channel (s_axis): each item carries func, data_in and offset.
//   func: push, pop (discard), pop and return, peek at an offset from the
//   front, or drop a number of front bytes. Unknown codes are refused.
// Output channel (m_axis): exactly one result item per input item, in
//   order, with data_out, ok, count, empty_res and full_res.
// Result path: the accept cycle issues the RAM access and loads the
//   middle stage; the read byte is then registered in the output register.
// Throughput: one item per cycle while the receiver takes results. Pointers
//   and fill count update in the accept cycle, so the next item sees them at
//   once; a read by a later item always sees an earlier write to the same slot.
// Stall: a result waiting in the output register lets one more item get
//   accepted into the middle stage; after that s_axis_tready drops until
//   the receiver takes the waiting result.
// Reset: pointers, fill count and the written-slot mark clear immediately.
//   The byte store itself is not cleared: slots at or above the written
//   mark (tail has never reached them) read back as zero, matching a store
//   cleared to zero. No clearing pass is needed, so items are taken from
//   the first cycle after reset.
module circular_byte_queue
  import cbq_pkg::*;
#(
  parameter int DEPTH = CBQ_DEPTH,
  localparam int CntW = $clog2(DEPTH + 1),
  localparam int OutRawW = DATA_W + 1 + CntW + 1 + 1,
  localparam int OutW = ((OutRawW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // s_axis_tdata fields from bit 0: func[2:0], data_in[7:0], offset[6:0], zero pad
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  // m_axis_tdata fields from bit 0: data_out[7:0], ok, count[CntW-1:0],
  // empty_res, full_res, zero pad
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CmpW  = (CntW > OFFS_W) ? CntW : OFFS_W;
  localparam int OffsN = 2 ** OFFS_W;

  // Unpack the input item.
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [OFFS_W-1:0] offset;

  assign func    = s_axis_tdata[FUNC_W-1:0];
  assign data_in = s_axis_tdata[FUNC_W+DATA_W-1:FUNC_W];
  assign offset  = s_axis_tdata[IN_RAW_W-1:FUNC_W+DATA_W];

  // Queue state.
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  fill_q, fill_d;
  // Number of slots written since reset; saturates at DEPTH after the first wrap.
  logic [CntW-1:0]  mark_q, mark_d;

  // Middle stage: RAM access in flight.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_ok_q;
  logic             s1_live_q;
  logic [CntW-1:0]  s1_count_q;

  // Output register.
  logic             m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q;
  logic             m_ok_q;
  logic [CntW-1:0]  m_count_q;

  // RAM ports.
  logic              wr_en;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic accept;
  logic s1_move;
  logic op_ok;
  logic rd_live;

  // offset mod DEPTH, worked out at elaboration for every offset code.
  logic [AddrW-1:0] off_mod_tbl [OffsN];

  for (genvar gi = 0; gi < OffsN; gi++) begin : g_off_mod
    assign off_mod_tbl[gi] = AddrW'(gi % DEPTH);
  end

  // Add two in-range indices and wrap once at DEPTH.
  function automatic logic [AddrW-1:0] wrap_add(logic [AddrW-1:0] a, logic [AddrW-1:0] b);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AddrW+1)'(DEPTH)) begin
      sum = sum - (AddrW+1)'(DEPTH);
    end
    return sum[AddrW-1:0];
  endfunction

  logic [AddrW-1:0] head_inc;
  logic [AddrW-1:0] tail_inc;
  logic [AddrW-1:0] head_off;
  logic [CmpW-1:0]  fill_ext;
  logic [CmpW-1:0]  offs_ext;
  logic             is_full;
  logic             is_empty;

  assign head_inc = wrap_add(head_q, AddrW'(1));
  assign tail_inc = wrap_add(tail_q, AddrW'(1));
  assign head_off = wrap_add(head_q, off_mod_tbl[offset]);
  assign fill_ext = CmpW'(fill_q);
  assign offs_ext = CmpW'(offset);
  assign is_full  = (fill_q == CntW'(DEPTH));
  assign is_empty = (fill_q == '0);

  // Handshakes: the middle stage drains whenever the output register is free
  // or being emptied this cycle.
  assign s1_move       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    mark_d  = mark_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = head_q;
    rd_live = 1'b0;
    op_ok   = 1'b0;
    if (accept) begin
      case (func)
        FUNC_PUSH: begin
          if (!is_full) begin
            wr_en  = 1'b1;
            tail_d = tail_inc;
            fill_d = fill_q + CntW'(1);
            op_ok  = 1'b1;
            // Advance the written mark while tail is still on fresh slots.
            if ((CntW'(tail_q) == mark_q) && (mark_q != CntW'(DEPTH))) begin
              mark_d = mark_q + CntW'(1);
            end
          end
        end
        FUNC_POP: begin
          if (!is_empty) begin
            head_d = head_inc;
            fill_d = fill_q - CntW'(1);
            op_ok  = 1'b1;
          end
        end
        FUNC_POP_RET: begin
          if (!is_empty) begin
            rd_en   = 1'b1;
            rd_addr = head_q;
            rd_live = (CntW'(head_q) < mark_q);
            head_d  = head_inc;
            fill_d  = fill_q - CntW'(1);
            op_ok   = 1'b1;
          end
        end
        FUNC_PEEK: begin
          rd_en   = 1'b1;
          rd_addr = head_off;
          rd_live = (CntW'(head_off) < mark_q);
          op_ok   = 1'b1;
        end
        FUNC_DROP: begin
          if (offs_ext <= fill_ext) begin
            head_d = head_off;
            fill_d = CntW'(fill_ext - offs_ext);
            op_ok  = 1'b1;
          end
        end
        default: begin
          // Refuse unknown codes; hold all state.
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (s1_move) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      mark_q     <= '0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      mark_q     <= mark_d;
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ok_q    <= op_ok;
      s1_live_q  <= rd_live;
      s1_count_q <= fill_d;
    end
    if (s1_move) begin
      m_data_q  <= s1_live_q ? rd_data : '0;
      m_ok_q    <= s1_ok_q;
      m_count_q <= s1_count_q;
    end
  end

  cbq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (data_in),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = m_valid_q;

  // Pack the result item; flags come straight from the registered count.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OutRawW-1:0] = {
      (m_count_q == CntW'(DEPTH)),
      (m_count_q == '0),
      m_count_q,
      m_ok_q,
      m_data_q
    };
  end

endmodule

/* sv/cbq_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module cbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sim/cbq_checker.sv */
// Result checker for the circular byte queue: tracks queue state, predicts and compares results.
module cbq_checker
  import cbq_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int OUT_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [IN_W-1:0]  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [OUT_W-1:0] out_data_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               checked_o,
  output int               refused_o,
  output int               full_seen_o,
  output int               empty_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] byte_out;
    logic              ok;
    logic [CNT_W-1:0]  level;
    logic              is_empty;
    logic              is_full;
  } queue_result_t;

  // Shadow copy of the ring buffer
  logic [DATA_W-1:0] queue_bytes [CBQ_DEPTH];
  int                front_idx;
  int                back_idx;
  int                level;

  queue_result_t expected_results [$];
  queue_result_t seen_res;
  queue_result_t wanted_res;

  function automatic string describe_result(input queue_result_t r);
    return $sformatf("data=%02h ok=%0b count=%0d empty=%0b full=%0b",
                     r.byte_out, r.ok, r.level, r.is_empty, r.is_full);
  endfunction

  // Apply one operation to the shadow buffer and return the result it gives.
  function automatic queue_result_t apply_queue_op(input logic [FUNC_W-1:0] op,
                                                   input logic [DATA_W-1:0] byte_in,
                                                   input logic [OFFS_W-1:0] offs);
    queue_result_t res;
    res = '0;
    case (op)
      FUNC_PUSH: begin
        if (level < CBQ_DEPTH) begin
          queue_bytes[back_idx] = byte_in;
          back_idx = (back_idx + 1) % CBQ_DEPTH;
          level++;
          res.ok = 1'b1;
        end
      end
      FUNC_POP: begin
        if (level != 0) begin
          front_idx = (front_idx + 1) % CBQ_DEPTH;
          level--;
          res.ok = 1'b1;
        end
      end
      FUNC_POP_RET: begin
        if (level != 0) begin
          res.byte_out = queue_bytes[front_idx];
          front_idx = (front_idx + 1) % CBQ_DEPTH;
          level--;
          res.ok = 1'b1;
        end
      end
      FUNC_PEEK: begin
        // any slot may be read, queued or not
        res.byte_out = queue_bytes[(front_idx + int'(offs)) % CBQ_DEPTH];
        res.ok = 1'b1;
      end
      FUNC_DROP: begin
        if (int'(offs) <= level) begin
          front_idx = (front_idx + int'(offs)) % CBQ_DEPTH;
          level -= int'(offs);
          res.ok = 1'b1;
        end
      end
      default: begin
        // spare codes: refuse, change nothing
      end
    endcase
    res.level    = CNT_W'(level);
    res.is_empty = (level == 0);
    res.is_full  = (level == CBQ_DEPTH);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (queue_bytes[i]) queue_bytes[i] = '0;
      front_idx = 0;
      back_idx = 0;
      level = 0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o = 0;
      checked_o = 0;
      refused_o = 0;
      full_seen_o = 0;
      empty_seen_o = 0;
    end else begin
      // Compare first: a result always belongs to an earlier item
      if (out_valid_i && out_ready_i) begin
        seen_res.byte_out = out_data_i[DATA_W-1:0];
        seen_res.ok       = out_data_i[DATA_W];
        seen_res.level    = out_data_i[DATA_W+1 +: CNT_W];
        seen_res.is_empty = out_data_i[DATA_W+1+CNT_W];
        seen_res.is_full  = out_data_i[DATA_W+2+CNT_W];
        if (expected_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected result, nothing pending: %s",
                     $time, describe_result(seen_res));
        end else begin
          wanted_res = expected_results.pop_front();
          checked_o++;
          if (!wanted_res.ok) refused_o++;
          if (wanted_res.is_full) full_seen_o++;
          if (wanted_res.is_empty) empty_seen_o++;
          if (seen_res !== wanted_res) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: mismatch: expected %s, got %s", $time,
                       describe_result(wanted_res), describe_result(seen_res));
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_queue_op(in_data_i[FUNC_W-1:0],
                                                  in_data_i[FUNC_W +: DATA_W],
                                                  in_data_i[FUNC_W+DATA_W +: OFFS_W]));
      pending_o = expected_results.size();
    end
  end

endmodule

/* sim/tb_circular_byte_queue.sv */
// Testbench top for the circular byte queue: clock, reset, stimulus, receiver and verdict.
module tb_circular_byte_queue;
  import cbq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CntW = $clog2(CBQ_DEPTH + 1);
  localparam int OutW = ((DATA_W + CntW + 3 + 7) / 8) * 8;

  localparam int RandomItems = 1550;
  localparam int LongHold    = 150;
  localparam int EndSettle   = 8;

  // Codes past the last operation; the block must refuse them
  localparam logic [FUNC_W-1:0] FuncSpareLo = 3'd5;
  localparam logic [FUNC_W-1:0] FuncSpareHi = 3'd7;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  // fields from bit 0: func, data_in, offset, zero pad
  logic [IN_W-1:0] s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  // fields from bit 0: data_out, ok, count, empty_res, full_res, zero pad
  logic [OutW-1:0] m_axis_tdata;

  int mismatch_total;
  int queue_pending;
  int results_checked;
  int refused_total;
  int full_total;
  int empty_total;

  int   items_sent = 0;
  int   burst_left = 0;
  logic hold_request = 1'b0;
  bit   hold_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circular_byte_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cbq_checker #(
    .CNT_W (CntW),
    .OUT_W (OutW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .mismatches_o (mismatch_total),
    .pending_o    (queue_pending),
    .checked_o    (results_checked),
    .refused_o    (refused_total),
    .full_seen_o  (full_total),
    .empty_seen_o (empty_total)
  );

  // Offer one item from a falling edge and hold it until accepted; then
  // advance the burst and insert a random gap when the burst runs out.
  task automatic offer_item(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] byte_in,
                            input logic [OFFS_W-1:0] offs);
    int gap;
    s_axis_tdata = IN_W'({offs, byte_in, op});
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // One random operation; push_pct steers the fill level up or down.
  task automatic offer_random_op(input int push_pct);
    int                sel;
    logic [FUNC_W-1:0] op;
    logic [OFFS_W-1:0] offs;
    offs = OFFS_W'($urandom_range(0, CBQ_DEPTH));
    if ($urandom_range(0, 99) < push_pct) begin
      op = FUNC_PUSH;
    end else begin
      sel = $urandom_range(0, 39);
      if (sel < 10) op = FUNC_POP;
      else if (sel < 20) op = FUNC_POP_RET;
      else if (sel < 30) op = FUNC_PEEK;
      else if (sel < 39) op = FUNC_DROP;
      else op = FUNC_W'($urandom_range(FuncSpareLo, FuncSpareHi));
      // mostly small drops so that many of them succeed
      if (op == FUNC_DROP && $urandom_range(0, 9) < 7) offs = OFFS_W'($urandom_range(0, 4));
    end
    offer_item(op, DATA_W'($urandom_range(0, 255)), offs);
  endtask

  // Drop the valid and hold off until every pending result has come back.
  task automatic drain_queue();
    s_axis_tvalid = 1'b0;
    wait (queue_pending == 0);
    @(negedge clk_i);
  endtask

  // Result side: change mode after each random span; serve a long hold-off on request.
  initial begin
    int mode;
    int span;
    int tick;
    m_axis_tready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (hold_request) begin
          hold_request = 1'b0;
          m_axis_tready = 1'b0;
          repeat (LongHold) @(negedge clk_i);
        end
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = $urandom_range(0, 1);
          2: m_axis_tready = (tick % 3 != 0);
          default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int kind;
    int span;
    int random_start;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: refusals on an empty queue, reset contents, peek wrap,
    // byte extremes, drop limits and the spare codes.
    offer_item(FUNC_POP, 8'h00, 7'd0);
    offer_item(FUNC_POP_RET, 8'hFF, 7'd0);
    offer_item(FUNC_DROP, 8'h00, 7'd1);
    offer_item(FUNC_DROP, 8'h00, 7'd0);
    offer_item(FUNC_PEEK, 8'h00, 7'd0);
    offer_item(FUNC_PEEK, 8'h00, OFFS_W'(CBQ_DEPTH));
    offer_item(FUNC_PUSH, 8'h00, OFFS_W'(CBQ_DEPTH));
    offer_item(FUNC_PUSH, 8'hFF, 7'd0);
    offer_item(FUNC_PUSH, 8'h80, 7'd0);
    offer_item(FUNC_PEEK, 8'h00, 7'd1);
    offer_item(FUNC_PEEK, 8'h00, 7'd2);
    offer_item(FUNC_PEEK, 8'h00, OFFS_W'(CBQ_DEPTH - 1));
    offer_item(FUNC_POP_RET, 8'h00, 7'd0);
    offer_item(FUNC_POP, 8'h00, 7'd0);
    offer_item(FUNC_DROP, 8'h00, 7'd2);
    offer_item(FUNC_DROP, 8'h00, 7'd1);
    offer_item(FUNC_POP_RET, 8'h00, 7'd0);
    offer_item(FuncSpareLo, 8'hFF, OFFS_W'(CBQ_DEPTH));
    offer_item(FuncSpareLo + 3'd1, 8'hFF, OFFS_W'(CBQ_DEPTH));
    offer_item(FuncSpareHi, 8'hFF, OFFS_W'(CBQ_DEPTH));
    offer_item(FUNC_PUSH, 8'h55, 7'd0);
    drain_queue();

    // Random: phases that fill, drain or churn the queue, runs to the brim,
    // pauses until drained, and one long receiver hold-off.
    random_start = items_sent;
    while (items_sent < random_start + RandomItems) begin
      if (!hold_done && items_sent - random_start > RandomItems / 3) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
        burst_left = 200;
        repeat (80) offer_random_op(90);
      end
      kind = $urandom_range(0, 9);
      span = $urandom_range(40, 160);
      case (kind)
        0, 1, 2: begin
          repeat (span) offer_random_op(85);
        end
        3, 4, 5: begin
          repeat (span) offer_random_op(15);
        end
        6, 7: begin
          repeat (span) offer_random_op(45);
        end
        8: begin
          // overfill from any level, then empty it with one maximal drop
          repeat (CBQ_DEPTH + 6) offer_item(FUNC_PUSH, DATA_W'($urandom_range(0, 255)),
                                            OFFS_W'($urandom_range(0, CBQ_DEPTH)));
          offer_item(FUNC_PEEK, 8'h00, OFFS_W'($urandom_range(0, CBQ_DEPTH)));
          offer_item(FUNC_DROP, 8'h00, OFFS_W'(CBQ_DEPTH));
          offer_item(FUNC_POP, 8'h00, 7'd0);
        end
        default: begin
          drain_queue();
        end
      endcase
    end

    s_axis_tvalid = 1'b0;
    wait (queue_pending == 0);
    repeat (EndSettle) @(posedge clk_i);

    $display("Run covered %0d items, %0d results checked: %0d refused, %0d full, %0d empty.",
             items_sent, results_checked, refused_total, full_total, empty_total);
    $display("Included a %0d-cycle receiver hold-off and drained pauses; %0d mismatches.",
             LongHold, mismatch_total);
    if (mismatch_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Simulation time limit reached with %0d results outstanding.", queue_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
